@@ hw/rtl/bpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared types, codes and midpoint helpers for the path flattener.
// ----------------------------------------------------------------------------
package bpf_pkg;

    localparam int CW            = 32;
    localparam int LIM_W         = 31;
    localparam int TOL_W         = 16;
    localparam int LVL_W         = 3;  // holds any split depth up to six
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_DEPTH_DEF = 6;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] OP_MOVE  = 2'd0;
    localparam logic [1:0] OP_LINE  = 2'd1;
    localparam logic [1:0] OP_QUAD  = 2'd2;
    localparam logic [1:0] OP_CUBIC = 2'd3;

    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_QUAD_LIM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUBIC_LIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_TOL  = 2'd2;

    localparam logic [LIM_W-1:0] QUAD_LIM_RST  = 31'd655;
    localparam logic [LIM_W-1:0] CUBIC_LIM_RST = 31'd32768;
    localparam logic [TOL_W-1:0] ZERO_TOL_RST  = 16'd16;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } bpf_pt_t;

    typedef struct packed {
        logic [1:0]       op;
        bpf_pt_t          p0;
        bpf_pt_t          p1;
        bpf_pt_t          p2;
        bpf_pt_t          p3;
        logic [LVL_W-1:0] level;
    } bpf_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bpf_q_stat_t;

    // floor((a+b)/2)
    function automatic coord_t avg2(coord_t a, coord_t b);
        logic signed [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        return s[CW:1];
    endfunction

    // floor((a+2b+c)/4)
    function automatic coord_t avg4(coord_t a, coord_t b, coord_t c);
        logic signed [CW+1:0] s;
        s = (CW+2)'(a) + ((CW+2)'(b) <<< 1) + (CW+2)'(c);
        return s[CW+1:2];
    endfunction

    // floor((a+3b+3c+d)/8)
    function automatic coord_t avg8(coord_t a, coord_t b, coord_t c, coord_t d);
        logic signed [CW+2:0] s;
        s = (CW+3)'(a) + 3 * (CW+3)'(b) + 3 * (CW+3)'(c) + (CW+3)'(d);
        return s[CW+2:3];
    endfunction

    function automatic bpf_pt_t pavg2(bpf_pt_t a, bpf_pt_t b);
        bpf_pt_t r;
        r.x = avg2(a.x, b.x);
        r.y = avg2(a.y, b.y);
        return r;
    endfunction

    function automatic bpf_pt_t pavg4(bpf_pt_t a, bpf_pt_t b, bpf_pt_t c);
        bpf_pt_t r;
        r.x = avg4(a.x, b.x, c.x);
        r.y = avg4(a.y, b.y, c.y);
        return r;
    endfunction

    function automatic bpf_pt_t pavg8(bpf_pt_t a, bpf_pt_t b, bpf_pt_t c, bpf_pt_t d);
        bpf_pt_t r;
        r.x = avg8(a.x, b.x, c.x, d.x);
        r.y = avg8(a.y, b.y, c.y, d.y);
        return r;
    endfunction

endpackage

@@ hw/rtl/bpf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_if
// Command and segment channels of the path flattener.
// ----------------------------------------------------------------------------
interface bpf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] pt0_x;
    logic [31:0] pt0_y;
    logic [31:0] pt1_x;
    logic [31:0] pt1_y;
    logic [31:0] pt2_x;
    logic [31:0] pt2_y;
    logic [31:0] pt3_x;
    logic [31:0] pt3_y;

    modport source (output valid, op, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y,
                    pt3_x, pt3_y, input ready);
    modport sink   (input valid, op, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y,
                    pt3_x, pt3_y, output ready);
endinterface

interface bpf_seg_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] seg_start_x;
    logic [31:0] seg_start_y;
    logic [31:0] seg_end_x;
    logic [31:0] seg_end_y;
    logic        last;

    modport source (output valid, kind, seg_start_x, seg_start_y, seg_end_x,
                    seg_end_y, last, input ready);
    modport sink   (input valid, kind, seg_start_x, seg_start_y, seg_end_x,
                    seg_end_y, last, output ready);
endinterface

@@ hw/rtl/bpf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_front
// Accepts commands and works out the uniform split level of quadratics.
// ----------------------------------------------------------------------------
module bpf_front #(
    parameter int MAX_DEPTH = bpf_pkg::MAX_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bpf_cmd_if.sink                   cmd,
    input  logic [bpf_pkg::LIM_W-1:0] quad_lim,
    input  logic [bpf_pkg::TOL_W-1:0] zero_tol,
    output bpf_pkg::bpf_cmd_t         push_cmd,
    output logic                      push,
    input  logic                      q_full
);
    import bpf_pkg::*;

    localparam int DW = CW + 1;

    logic             hold_reg, hold_next;
    logic             phase_reg, phase_next;
    bpf_cmd_t         item_reg;
    logic [DW-1:0]    dev_reg;
    logic [DW-1:0]    dev_next;
    logic [LVL_W-1:0] level;

    assign cmd.ready = !hold_reg;

    // Deviation: |p0 + p2 - 2*p1| per axis, with the near-zero axis dropped
    function automatic logic [DW-1:0] qdev(coord_t a, coord_t b, coord_t c);
        logic signed [DW:0] s;
        s = (DW+1)'(a) + (DW+1)'(c) - ((DW+1)'(b) <<< 1);
        return s[DW] ? DW'(-s) : DW'(s);
    endfunction

    always_comb
    begin
        logic [DW-1:0] dx;
        logic [DW-1:0] dy;
        dx = qdev(item_reg.p0.x, item_reg.p1.x, item_reg.p2.x);
        dy = qdev(item_reg.p0.y, item_reg.p1.y, item_reg.p2.y);
        if (dx <= DW'(zero_tol))
            dev_next = dy;
        else if (dy <= DW'(zero_tol))
            dev_next = dx;
        else
            dev_next = (dx < dy) ? dx : dy;
    end

    // Level: zero below the limit, else the first k with dev >> 2k at or below it, capped
    always_comb
    begin
        level = LVL_W'(MAX_DEPTH);
        for (int k = MAX_DEPTH; k >= 1; k--)
        begin
            if ((dev_reg >> (2 * k)) <= DW'(quad_lim))
                level = LVL_W'(k);
        end
        if (dev_reg < DW'(quad_lim))
            level = '0;
    end

    always_comb
    begin
        push_cmd       = item_reg;
        push_cmd.level = (item_reg.op == OP_QUAD) ? level : '0;
        push           = hold_reg && phase_reg && !q_full;
        hold_next      = hold_reg;
        phase_next     = phase_reg;
        if (!hold_reg && cmd.valid)
        begin
            hold_next  = 1'b1;
            phase_next = 1'b0;
        end
        else if (hold_reg && !phase_reg)
            phase_next = 1'b1;
        else if (push)
            hold_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            hold_reg  <= hold_next;
            phase_reg <= phase_next;
        end
    end

    // Payload and deviation capture
    always_ff @(posedge clk)
    begin
        if (!hold_reg && cmd.valid)
        begin
            item_reg.op   <= cmd.op;
            item_reg.p0   <= {cmd.pt0_x, cmd.pt0_y};
            item_reg.p1   <= {cmd.pt1_x, cmd.pt1_y};
            item_reg.p2   <= {cmd.pt2_x, cmd.pt2_y};
            item_reg.p3   <= {cmd.pt3_x, cmd.pt3_y};
            item_reg.level <= '0;
        end
        if (hold_reg && !phase_reg)
            dev_reg <= dev_next;
    end

endmodule

@@ hw/rtl/bpf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_queue
// Short command queue between the front and the subdivision engine.
// ----------------------------------------------------------------------------
module bpf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bpf_pkg::bpf_cmd_t push_cmd,
    input  logic              pop,
    output bpf_pkg::bpf_cmd_t pop_cmd,
    output bpf_pkg::bpf_q_stat_t stat
);
    import bpf_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    bpf_cmd_t      mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign stat.full  = (cnt_reg == (AW+1)'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_cmd    = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

@@ hw/rtl/bpf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpf_back
// Subdivision engine: splits curves on a piece stack and emits segments.
// ----------------------------------------------------------------------------
module bpf_back #(
    parameter int MAX_DEPTH = bpf_pkg::MAX_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bpf_pkg::LIM_W-1:0] cubic_lim,
    input  bpf_pkg::bpf_cmd_t         q_cmd,
    input  logic                      q_empty,
    output logic                      pop,
    bpf_seg_if.source                 seg
);
    import bpf_pkg::*;

    localparam int SP_W = $clog2(MAX_DEPTH + 1);
    localparam int IX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int MW   = CW + 3;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_ACT  = 2'd2;

    typedef struct packed {
        bpf_pt_t          s;
        bpf_pt_t          c1;
        bpf_pt_t          c2;
        bpf_pt_t          e;
        logic [LVL_W-1:0] depth;
    } piece_t;

    logic [1:0]       state_reg, state_next;
    piece_t           cur_reg, cur_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             cubic_reg, cubic_next;
    logic             split_reg, split_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    piece_t           stack [MAX_DEPTH];
    logic             push;
    piece_t           push_piece;
    bpf_pt_t          pen_reg, pen_next;
    logic             ov_reg, ov_next;
    logic             kind_reg, kind_next;
    logic             last_reg, last_next;
    bpf_pt_t          os_reg, os_next;
    bpf_pt_t          oe_reg, oe_next;
    logic             out_free;
    logic [SP_W-1:0]  sp_dec;

    assign seg.valid       = ov_reg;
    assign seg.kind        = kind_reg;
    assign seg.last        = last_reg;
    assign seg.seg_start_x = os_reg.x;
    assign seg.seg_start_y = os_reg.y;
    assign seg.seg_end_x   = oe_reg.x;
    assign seg.seg_end_y   = oe_reg.y;
    assign out_free        = !ov_reg || seg.ready;
    assign sp_dec          = sp_reg - 1'b1;

    // Cubic flatness terms: |2a - 3b + c| per axis
    function automatic logic [MW-1:0] cmag(coord_t a, coord_t b, coord_t c);
        logic signed [MW-1:0] s;
        s = ((MW)'(a) <<< 1) - 3 * (MW)'(b) + (MW)'(c);
        return s[MW-1] ? MW'(-s) : MW'(s);
    endfunction

    function automatic logic [MW-1:0] umin(logic [MW-1:0] a, logic [MW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    always_comb
    begin
        logic [MW-1:0] d1;
        logic [MW-1:0] d2;
        logic          flat_fail;
        bpf_pt_t       l1, l2, r1, r2, m;
        state_next = state_reg;
        cur_next   = cur_reg;
        level_next = level_reg;
        cubic_next = cubic_reg;
        split_next = split_reg;
        sp_next    = sp_reg;
        pen_next   = pen_reg;
        ov_next    = ov_reg && !seg.ready;
        kind_next  = kind_reg;
        last_next  = last_reg;
        os_next    = os_reg;
        oe_next    = oe_reg;
        pop        = 1'b0;
        push       = 1'b0;

        d1 = umin(cmag(cur_reg.e.x, cur_reg.c2.x, cur_reg.s.x),
                  cmag(cur_reg.e.y, cur_reg.c2.y, cur_reg.s.y));
        d2 = umin(cmag(cur_reg.s.x, cur_reg.c1.x, cur_reg.e.x),
                  cmag(cur_reg.s.y, cur_reg.c1.y, cur_reg.e.y));
        flat_fail = (d1 > MW'(cubic_lim)) || (d2 > MW'(cubic_lim));

        // Halves of the current piece
        if (cubic_reg)
        begin
            l1 = pavg2(cur_reg.s, cur_reg.c1);
            r2 = pavg2(cur_reg.c2, cur_reg.e);
            l2 = pavg4(cur_reg.s, cur_reg.c1, cur_reg.c2);
            r1 = pavg4(cur_reg.c1, cur_reg.c2, cur_reg.e);
            m  = pavg8(cur_reg.s, cur_reg.c1, cur_reg.c2, cur_reg.e);
        end
        else
        begin
            l1 = pavg2(cur_reg.s, cur_reg.c1);
            r1 = pavg2(cur_reg.c1, cur_reg.e);
            m  = pavg4(cur_reg.s, cur_reg.c1, cur_reg.e);
            l2 = l1;
            r2 = r1;
        end
        push_piece = '{s: m, c1: r1, c2: r2, e: cur_reg.e, depth: cur_reg.depth + 1'b1};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_cmd.op == OP_MOVE || q_cmd.op == OP_LINE)
                    begin
                        if (out_free)
                        begin
                            pop       = 1'b1;
                            ov_next   = 1'b1;
                            last_next = 1'b1;
                            os_next   = q_cmd.p0;
                            if (q_cmd.op == OP_MOVE)
                            begin
                                kind_next = KIND_MOVE;
                                oe_next   = q_cmd.p0;
                                pen_next  = q_cmd.p0;
                            end
                            else
                            begin
                                kind_next = KIND_LINE;
                                oe_next   = q_cmd.p1;
                                pen_next  = q_cmd.p1;
                            end
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        cubic_next = (q_cmd.op == OP_CUBIC);
                        level_next = q_cmd.level;
                        sp_next    = '0;
                        cur_next   = '{s: q_cmd.p0, c1: q_cmd.p1, c2: q_cmd.p2,
                                       e: (q_cmd.op == OP_CUBIC) ? q_cmd.p3 : q_cmd.p2,
                                       depth: '0};
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                if (cubic_reg)
                    split_next = flat_fail && (cur_reg.depth < LVL_W'(MAX_DEPTH));
                else
                    split_next = cur_reg.depth < level_reg;
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                if (split_reg)
                begin
                    push       = 1'b1;
                    sp_next    = sp_reg + 1'b1;
                    cur_next   = '{s: cur_reg.s, c1: l1, c2: l2, e: m,
                                   depth: cur_reg.depth + 1'b1};
                    state_next = ST_EVAL;
                end
                else if (out_free)
                begin
                    ov_next   = 1'b1;
                    kind_next = KIND_LINE;
                    last_next = (sp_reg == '0);
                    os_next   = pen_reg;
                    oe_next   = cur_reg.e;
                    pen_next  = cur_reg.e;
                    if (sp_reg == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        cur_next   = stack[sp_dec[IX_W-1:0]];
                        sp_next    = sp_dec;
                        state_next = ST_EVAL;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sp_reg    <= '0;
            ov_reg    <= 1'b0;
            pen_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            ov_reg    <= ov_next;
            pen_reg   <= pen_next;
        end
    end

    // Payload and piece stack
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        level_reg <= level_next;
        cubic_reg <= cubic_next;
        split_reg <= split_next;
        kind_reg  <= kind_next;
        last_reg  <= last_next;
        os_reg    <= os_next;
        oe_reg    <= oe_next;
        if (push)
            stack[sp_reg[IX_W-1:0]] <= push_piece;
    end

endmodule

@@ hw/rtl/bezier_path_flattener_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_path_flattener_core
// Flattens move, line, quadratic and cubic path commands into line segments.
// ----------------------------------------------------------------------------
// The front takes one command at a time: it takes the item, works out the
// quadratic deviation, then sets the split level and writes the queue once
// the queue has room. A move or a line passes from the front through the
// queue to the output register of the engine. A curve cut into N segments
// (up to 2^MAX_DEPTH) visits 2*N-1 pieces; after it takes the command from the
// queue, the subdivision engine judges the flatness of each piece in its EVAL
// state, then splits it or emits it in its ACT state, paced by the single
// shared split unit and its piece stack. The front and a two-entry queue take
// further commands while the engine works, and the output register lets the
// engine keep judging and splitting while a segment waits to be taken; it
// stops only when it has the next segment ready to emit.
module bezier_path_flattener_core #(
    parameter int MAX_DEPTH = bpf_pkg::MAX_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpf_pkg::LIM_W-1:0]     cfg_data,
    bpf_cmd_if.sink                       cmd,
    bpf_seg_if.source                     seg
);
    import bpf_pkg::*;

    logic [LIM_W-1:0] quad_lim_reg;
    logic [LIM_W-1:0] cubic_lim_reg;
    logic [TOL_W-1:0] zero_tol_reg;
    bpf_cmd_t         push_cmd;
    bpf_cmd_t         pop_cmd;
    logic             push;
    logic             pop;
    bpf_q_stat_t      q_stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_lim_reg  <= QUAD_LIM_RST;
            cubic_lim_reg <= CUBIC_LIM_RST;
            zero_tol_reg  <= ZERO_TOL_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_QUAD_LIM)
                quad_lim_reg <= cfg_data;
            if (cfg_index == REG_CUBIC_LIM)
                cubic_lim_reg <= cfg_data;
            if (cfg_index == REG_ZERO_TOL)
                zero_tol_reg <= cfg_data[TOL_W-1:0];
        end
    end

    bpf_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .quad_lim (quad_lim_reg),
        .zero_tol (zero_tol_reg),
        .push_cmd (push_cmd),
        .push     (push),
        .q_full   (q_stat.full)
    );

    bpf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    bpf_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cubic_lim (cubic_lim_reg),
        .q_cmd     (pop_cmd),
        .q_empty   (q_stat.empty),
        .pop       (pop),
        .seg       (seg)
    );

    // Queue status can never read full and empty at once
    a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty together");

    // A move marker is always the only and final item of its command
    a_move_last: assert property (@(posedge clk) disable iff (!rst_n)
        (seg.valid && seg.kind == KIND_MOVE) |-> seg.last)
        else $error("move marker without last");

    // A move marker ends where it starts
    a_move_pt: assert property (@(posedge clk) disable iff (!rst_n)
        (seg.valid && seg.kind == KIND_MOVE) |->
        (seg.seg_start_x == seg.seg_end_x && seg.seg_start_y == seg.seg_end_y))
        else $error("move marker end differs from start");

    // No pop from an empty queue
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

@@ tb/bezier_path_flattener_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_path_flattener_core_test
// Drives move, line, quadratic and cubic commands into the flattener under
// several threshold settings, predicts every segment with a behavioral copy
// of the subdivision rules, and checks each segment item as it leaves.
// ----------------------------------------------------------------------------
module bezier_path_flattener_core_test;
    import bpf_pkg::*;

    localparam int DEPTH_CAP = MAX_DEPTH_DEF;

    typedef struct {
        logic        kind;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] ex;
        logic [31:0] ey;
        logic        last;
    } seg_item_t;

    logic clk;
    logic rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIM_W-1:0]     cfg_data;

    bpf_cmd_if cmd_ch();
    bpf_seg_if seg_ch();

    bezier_path_flattener_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .seg       (seg_ch)
    );

    // flattener state as the predictor sees it
    longint          pen_x_m;
    longint          pen_y_m;
    longint unsigned quad_lim_m;
    longint unsigned cubic_lim_m;
    longint unsigned zero_tol_m;

    seg_item_t pending_segs[$];
    seg_item_t cmd_segs[$];
    int        err_count;
    bit        idle_en;
    int        stall_left;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // segment prediction
    // ------------------------------------------------------------------
    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned min64(longint unsigned a, longint unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic void push_seg(logic k, longint ax, longint ay, longint bx, longint by);
        seg_item_t s;
        if (cmd_segs.size() >= (1 << DEPTH_CAP))
            return;
        s.kind = k;
        s.sx   = ax[31:0];
        s.sy   = ay[31:0];
        s.ex   = bx[31:0];
        s.ey   = by[31:0];
        s.last = 1'b0;
        cmd_segs.push_back(s);
    endfunction

    function automatic void line_to(longint ex, longint ey);
        push_seg(KIND_LINE, pen_x_m, pen_y_m, ex, ey);
        pen_x_m = ex;
        pen_y_m = ey;
    endfunction

    function automatic void quad_subdiv(longint sx, longint sy, longint cx, longint cy,
                                        longint ex, longint ey, int lvl);
        longint l1x, l1y, r1x, r1y, mx, my;
        if (lvl == 0)
        begin
            line_to(ex, ey);
            return;
        end
        l1x = (sx + cx) >>> 1;
        l1y = (sy + cy) >>> 1;
        r1x = (cx + ex) >>> 1;
        r1y = (cy + ey) >>> 1;
        mx  = (sx + 2 * cx + ex) >>> 2;
        my  = (sy + 2 * cy + ey) >>> 2;
        quad_subdiv(sx, sy, l1x, l1y, mx, my, lvl - 1);
        quad_subdiv(mx, my, r1x, r1y, ex, ey, lvl - 1);
    endfunction

    function automatic void cubic_subdiv(longint sx, longint sy, longint c1x, longint c1y,
                                         longint c2x, longint c2y, longint ex, longint ey,
                                         int dep);
        longint d1x, d1y, d2x, d2y;
        longint l1x, l1y, l2x, l2y, r1x, r1y, r2x, r2y, mx, my;
        bit     bend;
        d1x  = 2 * ex - 3 * c2x + sx;
        d1y  = 2 * ey - 3 * c2y + sy;
        d2x  = ex - 3 * c1x + 2 * sx;
        d2y  = ey - 3 * c1y + 2 * sy;
        bend = (min64(abs64(d1x), abs64(d1y)) > cubic_lim_m) ||
               (min64(abs64(d2x), abs64(d2y)) > cubic_lim_m);
        if (!bend || dep >= DEPTH_CAP)
        begin
            line_to(ex, ey);
            return;
        end
        l1x = (sx + c1x) >>> 1;
        l1y = (sy + c1y) >>> 1;
        r2x = (c2x + ex) >>> 1;
        r2y = (c2y + ey) >>> 1;
        l2x = (sx + 2 * c1x + c2x) >>> 2;
        l2y = (sy + 2 * c1y + c2y) >>> 2;
        r1x = (c1x + 2 * c2x + ex) >>> 2;
        r1y = (c1y + 2 * c2y + ey) >>> 2;
        mx  = (sx + 3 * c1x + 3 * c2x + ex) >>> 3;
        my  = (sy + 3 * c1y + 3 * c2y + ey) >>> 3;
        cubic_subdiv(sx, sy, l1x, l1y, l2x, l2y, mx, my, dep + 1);
        cubic_subdiv(mx, my, r1x, r1y, r2x, r2y, ex, ey, dep + 1);
    endfunction

    // works out every segment of one command and queues them
    function automatic void flatten_cmd(logic [1:0] op, logic [31:0] pt[8]);
        longint          c[8];
        longint unsigned dx, dy, dev;
        int              lvl;
        for (int i = 0; i < 8; i++)
            c[i] = longint'($signed(pt[i]));
        cmd_segs.delete();
        case (op)
            OP_MOVE:
            begin
                pen_x_m = c[0];
                pen_y_m = c[1];
                push_seg(KIND_MOVE, c[0], c[1], c[0], c[1]);
            end
            OP_LINE:
            begin
                push_seg(KIND_LINE, c[0], c[1], c[2], c[3]);
                pen_x_m = c[2];
                pen_y_m = c[3];
            end
            OP_QUAD:
            begin
                dx  = abs64(c[0] + c[4] - 2 * c[2]);
                dy  = abs64(c[1] + c[5] - 2 * c[3]);
                lvl = 0;
                if (dx <= zero_tol_m)
                    dev = dy;
                else if (dy <= zero_tol_m)
                    dev = dx;
                else
                    dev = min64(dx, dy);
                if (dev >= quad_lim_m)
                begin
                    do
                    begin
                        dev = dev >> 2;
                        lvl++;
                    end while (dev > quad_lim_m && lvl < DEPTH_CAP);
                end
                quad_subdiv(c[0], c[1], c[2], c[3], c[4], c[5], lvl);
            end
            default:
                cubic_subdiv(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], 0);
        endcase
        cmd_segs[cmd_segs.size() - 1].last = 1'b1;
        foreach (cmd_segs[i])
            pending_segs.push_back(cmd_segs[i]);
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        err_count++;
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
    endtask

    task automatic send_cmd(logic [1:0] op, logic [31:0] x0, logic [31:0] y0,
                            logic [31:0] x1, logic [31:0] y1, logic [31:0] x2,
                            logic [31:0] y2, logic [31:0] x3, logic [31:0] y3);
        logic [31:0] pt[8];
        int          gap;
        pt = '{x0, y0, x1, y1, x2, y2, x3, y3};
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            repeat (gap)
            begin
                @(negedge clk);
                cmd_ch.valid = 1'b0;
            end
        end
        @(negedge clk);
        cmd_ch.valid = 1'b1;
        cmd_ch.op    = op;
        cmd_ch.pt0_x = x0;
        cmd_ch.pt0_y = y0;
        cmd_ch.pt1_x = x1;
        cmd_ch.pt1_y = y1;
        cmd_ch.pt2_x = x2;
        cmd_ch.pt2_y = y2;
        cmd_ch.pt3_x = x3;
        cmd_ch.pt3_y = y3;
        flatten_cmd(op, pt);
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // lets the block run dry before anything changes its settings
    task automatic drain_segs();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending_segs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_QUAD_LIM:  quad_lim_m  = 64'(val);
            REG_CUBIC_LIM: cubic_lim_m = 64'(val);
            default:       zero_tol_m  = 64'(val[TOL_W-1:0]);
        endcase
    endtask

    task automatic set_limits(logic [LIM_W-1:0] ql, logic [LIM_W-1:0] cl,
                              logic [LIM_W-1:0] zt);
        drain_segs();
        write_reg(REG_QUAD_LIM, ql);
        write_reg(REG_CUBIC_LIM, cl);
        write_reg(REG_ZERO_TOL, zt);
    endtask

    function automatic logic [31:0] near_coord(logic [31:0] base);
        int sh;
        sh = $urandom_range(2, 22);
        return base + ($urandom & ((32'd1 << sh) - 1)) - (32'd1 << (sh - 1));
    endfunction

    // one random command; most are curves in a local neighborhood
    task automatic send_random_cmd();
        logic [31:0] base;
        logic [31:0] p[8];
        logic [1:0]  op;
        if ($urandom_range(0, 9) < 2)
            op = ($urandom_range(0, 1) == 0) ? OP_MOVE : OP_LINE;
        else
            op = OP_QUAD;
        if ($urandom_range(0, 1) == 1 && op == OP_QUAD)
            op = OP_CUBIC;
        base = $urandom;
        for (int i = 0; i < 8; i++)
            p[i] = ($urandom_range(0, 7) == 0) ? $urandom : near_coord(base);
        send_cmd(op, p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
    endtask

    // ------------------------------------------------------------------
    // segment checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        seg_item_t want;
        if (rst_n && seg_ch.valid && seg_ch.ready)
        begin
            if (pending_segs.size() == 0)
                report_mismatch("segment item with none expected", '0, seg_ch.seg_end_x);
            else
            begin
                want = pending_segs.pop_front();
                if (seg_ch.kind !== want.kind)
                    report_mismatch("kind", 32'(want.kind), 32'(seg_ch.kind));
                if (seg_ch.seg_start_x !== want.sx)
                    report_mismatch("seg_start_x", want.sx, seg_ch.seg_start_x);
                if (seg_ch.seg_start_y !== want.sy)
                    report_mismatch("seg_start_y", want.sy, seg_ch.seg_start_y);
                if (seg_ch.seg_end_x !== want.ex)
                    report_mismatch("seg_end_x", want.ex, seg_ch.seg_end_x);
                if (seg_ch.seg_end_y !== want.ey)
                    report_mismatch("seg_end_y", want.ey, seg_ch.seg_end_y);
                if (seg_ch.last !== want.last)
                    report_mismatch("last", 32'(want.last), 32'(seg_ch.last));
            end
        end
    end

    // receiver stalls in bursts
    always @(negedge clk)
    begin
        if (!idle_en)
            seg_ch.ready = 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            seg_ch.ready = 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left   = $urandom_range(0, 6);
            seg_ch.ready = 1'b0;
        end
        else
            seg_ch.ready = 1'b1;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // extremes of move and line
        send_cmd(OP_MOVE, 32'h7fffffff, 32'h80000000, '1, '1, '1, '1, '1, '1);
        send_cmd(OP_LINE, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                 0, 0, 0, 0);
        send_cmd(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 0);
        // straight quadratic: a single segment
        send_cmd(OP_QUAD, 0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000, '1, '1);
        // x deviation counted as zero, y decides
        send_cmd(OP_QUAD, 0, 0, 32'h10000, 32'h50000, 32'h20000, 0, 0, 0);
        // y deviation counted as zero, x decides
        send_cmd(OP_QUAD, 0, 0, 32'h50000, 32'h10000, 0, 32'h20000, 0, 0);
        // both deviations count, the smaller decides
        send_cmd(OP_QUAD, 0, 0, 32'h30000, 32'h80000, 32'h10000, 0, 0, 0);
        // deviation just below the limit does not split
        send_cmd(OP_QUAD, 0, 0, 32'd0, 32'hfffffeb9, 32'd655, 32'd0, 0, 0);
        // huge deviation saturates the split level
        send_cmd(OP_QUAD, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h80000000, 0, 0);
        // flat and bent cubics
        send_cmd(OP_CUBIC, 0, 0, 32'h10000, 0, 32'h20000, 0, 32'h30000, 0);
        send_cmd(OP_CUBIC, 0, 0, 32'h40000, 32'h80000, 32'hc0000, 32'hfff80000,
                 32'h100000, 0);
        send_cmd(OP_CUBIC, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    endtask

    task automatic test_limit_extremes();
        set_limits('0, '0, '0);
        send_cmd(OP_QUAD, 0, 0, 32'h1, 32'h3, 32'h4, 0, 0, 0);
        send_cmd(OP_QUAD, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(OP_CUBIC, 0, 0, 32'h100, 32'h200, 32'h300, 32'h100, 32'h400, 0);
        set_limits('1, '1, 31'h0000ffff);
        send_cmd(OP_QUAD, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 0, 0);
        send_cmd(OP_CUBIC, 32'h7fffffff, 0, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        send_cmd(OP_LINE, 1, 2, 3, 4, 0, 0, 0, 0);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 4; ph++)
        begin
            set_limits($urandom_range(0, 1) ? LIM_W'($urandom & 32'h0003ffff)
                                            : LIM_W'($urandom),
                       $urandom_range(0, 1) ? LIM_W'($urandom & 32'h000fffff)
                                            : LIM_W'($urandom),
                       LIM_W'($urandom & 32'h0000ffff));
            repeat (20) send_random_cmd();
        end
    endtask

    task automatic test_drain_pause();
        set_limits(31'd655, 31'd32768, 31'd16);
        repeat (4) send_random_cmd();
        // hold the sender until every segment is out
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending_segs.size() != 0)
            @(posedge clk);
        repeat (4) send_random_cmd();
    endtask

    task automatic test_full_rate();
        drain_segs();
        idle_en = 1'b0;
        repeat (12) send_random_cmd();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.op    = OP_MOVE;
        cmd_ch.pt0_x = '0;
        cmd_ch.pt0_y = '0;
        cmd_ch.pt1_x = '0;
        cmd_ch.pt1_y = '0;
        cmd_ch.pt2_x = '0;
        cmd_ch.pt2_y = '0;
        cmd_ch.pt3_x = '0;
        cmd_ch.pt3_y = '0;
        seg_ch.ready = 1'b0;
        idle_en      = 1'b1;
        stall_left   = 0;
        err_count    = 0;
        pen_x_m      = 0;
        pen_y_m      = 0;
        quad_lim_m   = 64'(QUAD_LIM_RST);
        cubic_lim_m  = 64'(CUBIC_LIM_RST);
        zero_tol_m   = 64'(ZERO_TOL_RST);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_limit_extremes();
        test_random_phases();
        test_drain_pause();
        test_full_rate();

        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending_segs.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("bezier_path_flattener_core_test: done, clean");
        else
            $display("bezier_path_flattener_core_test: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("bezier_path_flattener_core_test: done, errors");
        $finish;
    end

endmodule
